/* src/ira_pkg.sv */
// Shared types and constants for the IP range table lookup block.
package ira_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int NUM_LANES       = 8;
  localparam int LANE_W          = $clog2(NUM_LANES);

  typedef struct packed {
    logic [31:0] rng_start;
    logic [31:0] rng_last;
    logic [15:0] region;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

endpackage

/* src/ira_ram.sv */
// Generic simple dual-port RAM with registered read.
module ira_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ira_cell.sv */
// One lane of the table: a bank of entries, shifting into the next lane on insert.
module ira_cell #(
  parameter int ROWS  = 512,
  parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  parameter int CW    = ROW_W + ira_pkg::LANE_W + 1,
  parameter int LANE  = 0
) (
  input  logic                clk_i,
  input  logic [ROW_W-1:0]    rd_row_i,
  input  logic                wr_en_i,
  input  logic [ROW_W-1:0]    wr_row_i,
  input  logic [CW-1:0]       pos_i,
  input  logic [CW-1:0]       used_i,
  input  ira_pkg::entry_t     new_i,
  input  ira_pkg::entry_t     shift_i,
  output ira_pkg::entry_t     rd_o
);

  localparam int LW = ira_pkg::LANE_W;
  localparam logic [LW-1:0] LaneIdx = LW'(LANE);

  logic [CW-1:0]   idx;
  logic            we;
  ira_pkg::entry_t wdata;

  // entry index of this lane in the row being rewritten
  assign idx   = CW'({wr_row_i, LaneIdx});
  assign we    = wr_en_i && (idx >= pos_i) && (idx <= used_i);
  assign wdata = (idx == pos_i) ? new_i : shift_i;

  ira_ram #(
    .WIDTH ($bits(ira_pkg::entry_t)),
    .DEPTH (ROWS),
    .AW    (ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_row_i),
    .wdata_i (wdata),
    .raddr_i (rd_row_i),
    .rdata_o (rd_o)
  );

endmodule

/* src/ip_range_table_lookup.sv */
// IP range table: sorted IPv4 ranges held in a row of lane cells, binary-search lookup.
//
// Commands are taken when start is high and busy is low; busy stays high until the
// result beat, which appears on done_o for exactly one cycle and cannot be stalled.
// Entry i lives in lane (i mod 8), row (i / 8). A lookup or the slot search of an
// insert works in probes, each a RAM read and then a compare, with at most
// log2(count)+1 probes. An insert adds its slot search to a shift pass in which every
// lane hands its entry to the next, one row per cycle, from the insert row to the
// row that holds index count. Clear, a full-table insert and the unused opcode stay
// in idle and raise done_o in the cycle after start.
module ip_range_table_lookup #(
  parameter int TABLE_DEPTH = ira_pkg::TABLE_DEPTH_DEF,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode_i,
  input  logic [31:0]      ip_value_i,
  input  logic [31:0]      range_last_i,
  input  logic [15:0]      region_in_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [15:0]      region_out_o,
  output logic [CNT_W-1:0] entry_count_o
);

  localparam int LANES  = ira_pkg::NUM_LANES;
  localparam int LANE_W = ira_pkg::LANE_W;
  localparam int ROWS   = (TABLE_DEPTH + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = ROW_W + LANE_W + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_CHECK = 4'b0100,
    S_SHIFT = 4'b1000
  } state_e;

  state_e          state_q;
  logic            done_q, done_d;
  logic [1:0]      status_q;
  logic [15:0]     region_q;
  logic [CNT_W-1:0] used_q;

  logic            lookup_q;
  ira_pkg::entry_t req_q;
  logic [CNT_W-1:0] low_q, hx_q, mid_q;

  logic [ROW_W-1:0] rd_row_q, last_row_q, wr_row_q;
  logic            rd_done_q, wr_vld_q;
  ira_pkg::entry_t carry_q;

  logic [CNT_W-1:0] span, mid;
  logic [ROW_W-1:0] rd_addr;
  ira_pkg::entry_t  lane_rd [LANES];
  ira_pkg::entry_t  lane_in [LANES];
  ira_pkg::entry_t  sel;
  logic             go_left, hit, full;

  // lookup midpoint is floor over [low, high], slot search over [low, hi)
  assign span    = hx_q - low_q - CNT_W'(lookup_q);
  assign mid     = low_q + (span >> 1);
  assign rd_addr = (state_q == S_SHIFT) ? rd_row_q : ROW_W'(mid >> LANE_W);

  assign sel     = lane_rd[LANE_W'(mid_q)];
  assign go_left = sel.rng_start > req_q.rng_start;
  assign hit     = !go_left && (req_q.rng_start <= sel.rng_last);
  assign full    = (used_q == CNT_W'(TABLE_DEPTH));

  always_comb begin
    lane_in[0] = carry_q;
    for (int c = 1; c < LANES; c++) begin
      lane_in[c] = lane_rd[c-1];
    end
  end

  always_comb begin
    done_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        done_d = start && !((opcode_i == ira_pkg::OP_LOOKUP) ||
                            ((opcode_i == ira_pkg::OP_INSERT) && !full));
      end
      S_PROBE: begin
        done_d = (low_q >= hx_q) && lookup_q;
      end
      S_CHECK: begin
        done_d = lookup_q && hit;
      end
      S_SHIFT: begin
        done_d = wr_vld_q && (wr_row_q == last_row_q);
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ira_cell #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W),
      .CW    (CW),
      .LANE  (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rd_row_i (rd_addr),
      .wr_en_i  (wr_vld_q),
      .wr_row_i (wr_row_q),
      .pos_i    (CW'(low_q)),
      .used_i   (CW'(used_q)),
      .new_i    (req_q),
      .shift_i  (lane_in[g]),
      .rd_o     (lane_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      status_q   <= '0;
      region_q   <= '0;
      used_q     <= '0;
      lookup_q   <= 1'b0;
      req_q      <= '0;
      low_q      <= '0;
      hx_q       <= '0;
      mid_q      <= '0;
      rd_row_q   <= '0;
      last_row_q <= '0;
      wr_row_q   <= '0;
      rd_done_q  <= 1'b0;
      wr_vld_q   <= 1'b0;
      carry_q    <= '0;
    end else begin
      done_q <= done_d;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q    <= '{rng_start: ip_value_i, rng_last: range_last_i, region: region_in_i};
            low_q    <= '0;
            hx_q     <= used_q;
            status_q <= ((opcode_i == ira_pkg::OP_INSERT) && full) ? ira_pkg::ST_FULL
                                                                   : ira_pkg::ST_OK;
            region_q <= '0;
            case (opcode_i)
              ira_pkg::OP_INSERT: begin
                lookup_q <= 1'b0;
                if (!full) begin
                  state_q <= S_PROBE;
                end
              end
              ira_pkg::OP_LOOKUP: begin
                lookup_q <= 1'b1;
                state_q  <= S_PROBE;
              end
              ira_pkg::OP_CLEAR: begin
                used_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PROBE: begin
          if (low_q < hx_q) begin
            mid_q   <= mid;
            state_q <= S_CHECK;
          end else if (lookup_q) begin
            status_q <= ira_pkg::ST_MISS;
            state_q  <= S_IDLE;
          end else begin
            // slot found at low_q: shift rows from its row up to the row of used_q
            rd_row_q   <= ROW_W'(low_q >> LANE_W);
            last_row_q <= ROW_W'(used_q >> LANE_W);
            rd_done_q  <= 1'b0;
            wr_vld_q   <= 1'b0;
            state_q    <= S_SHIFT;
          end
        end
        S_CHECK: begin
          if (lookup_q && hit) begin
            region_q <= sel.region;
            state_q  <= S_IDLE;
          end else begin
            if (go_left) begin
              hx_q <= mid_q;
            end else begin
              low_q <= mid_q + CNT_W'(1);
            end
            state_q <= S_PROBE;
          end
        end
        S_SHIFT: begin
          if (!rd_done_q) begin
            if (rd_row_q == last_row_q) begin
              rd_done_q <= 1'b1;
            end else begin
              rd_row_q <= rd_row_q + ROW_W'(1);
            end
          end
          wr_vld_q <= !rd_done_q;
          wr_row_q <= rd_row_q;
          if (wr_vld_q) begin
            carry_q <= lane_rd[LANES-1];
            if (wr_row_q == last_row_q) begin
              used_q  <= used_q + CNT_W'(1);
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign region_out_o  = region_q;
  assign entry_count_o = used_q;

endmodule
